>>> design/qctm_pkg.sv
// Shared types, sizes and the channel quantizer for the quantized color tally.
// No dependencies.
package qctm_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int COUNT_WIDTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int USED_W      = $clog2(TABLE_DEPTH + 1);

    localparam int Q_LOW_EDGE  = 44;
    localparam int Q_TOP_EDGE  = 224;
    localparam int Q_BIN       = 20;
    localparam int Q_LOW_LVL   = 10;
    localparam int Q_FIRST_LVL = 53;
    localparam int Q_TOP_LVL   = 245;
    localparam int Q_BINS      = (Q_TOP_EDGE - Q_LOW_EDGE) / Q_BIN;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REPORT = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    typedef struct packed {
        logic [7:0]             blue;
        logic [7:0]             green;
        logic [7:0]             red;
        logic [COUNT_WIDTH-1:0] count;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } tbl_wr_t;

    function automatic logic [7:0] quantize(input logic [7:0] x);
        logic [7:0] lvl;
        lvl = 8'(Q_LOW_LVL);
        for (int k = 0; k <= Q_BINS; k++)
        begin
            if (x >= 8'(Q_LOW_EDGE + Q_BIN * k))
            begin
                lvl = (k == Q_BINS) ? 8'(Q_TOP_LVL) : 8'(Q_FIRST_LVL + Q_BIN * k);
            end
        end
        return lvl;
    endfunction

endpackage

>>> design/quantized_color_tally_mode.sv
// Top level of the quantized color tally: command sequencer, table scan, result register.
// Depends on qctm_pkg and qctm_table.
//
//   channel | direction | handshake          | word
//   in      | input     | in_valid/in_stall  | cmd, blue_in, green_in, red_in
//   out     | output    | out_valid/out_stall| mode_*, entries_used, table_empty, colors_dropped
//
// Add and report scan the used entries one read per cycle, bounded by the single table
// read port; an add stops at a matching entry, and a report then passes through the result
// register. Clear empties the table without a scan.
// Reset empties the table and clears the dropped flag; stored entries are not touched.
// A report result waits in the output register while a stall holds; the next word is
// taken meanwhile, and a later report waits until the register is free.
module quantized_color_tally_mode (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      cmd,
    input  logic [7:0]                      blue_in,
    input  logic [7:0]                      green_in,
    input  logic [7:0]                      red_in,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [7:0]                      mode_blue,
    output logic [7:0]                      mode_green,
    output logic [7:0]                      mode_red,
    output logic [qctm_pkg::COUNT_WIDTH-1:0] mode_count,
    output logic [qctm_pkg::USED_W-1:0]     entries_used,
    output logic                            table_empty,
    output logic                            colors_dropped
);
    import qctm_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } state_t;

    state_t              state_reg;
    cmd_t                cmd_reg;
    logic [7:0]          qb_reg, qg_reg, qr_reg;
    logic [USED_W-1:0]   used_reg;
    logic                ovf_reg;
    logic [USED_W-1:0]   rd_idx_reg;
    logic                pend_reg;
    logic [IDX_W-1:0]    pend_idx_reg;
    entry_t              best_reg;
    logic                out_valid_reg;
    logic [7:0]          out_b_reg, out_g_reg, out_r_reg;
    logic [COUNT_WIDTH-1:0] out_cnt_reg;
    logic [USED_W-1:0]   out_used_reg;
    logic                out_empty_reg;
    logic                out_drop_reg;

    tbl_wr_t             wr;
    entry_t              rd_data;
    logic                issue;
    logic                hit;
    logic                better;
    logic                scan_end;
    logic                room;
    logic                accept;
    logic                out_free;
    logic [COUNT_WIDTH-1:0] cnt_inc;

    qctm_table u_table (
        .clk     (clk),
        .wr      (wr),
        .rd_en   (issue),
        .rd_addr (rd_idx_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign room     = (used_reg < USED_W'(TABLE_DEPTH));

    assign hit = (state_reg == ST_SCAN) && pend_reg && (cmd_reg == CMD_ADD)
                 && (rd_data.blue == qb_reg) && (rd_data.green == qg_reg)
                 && (rd_data.red == qr_reg);
    assign issue    = (state_reg == ST_SCAN) && (rd_idx_reg < used_reg) && !hit;
    assign scan_end = (state_reg == ST_SCAN) && !issue && !hit;
    assign better   = pend_reg && ((pend_idx_reg == '0) || (rd_data.count > best_reg.count));
    assign cnt_inc  = (rd_data.count == '1) ? rd_data.count : rd_data.count + 1'b1;

    always_comb
    begin
        wr.en   = 1'b0;
        wr.addr = used_reg[IDX_W-1:0];
        wr.data = '{blue: qb_reg, green: qg_reg, red: qr_reg, count: '0};
        if (hit)
        begin
            wr.en         = 1'b1;
            wr.addr       = pend_idx_reg;
            wr.data.count = cnt_inc;
        end
        else if (scan_end && (cmd_reg == CMD_ADD) && room)
        begin
            wr.en = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cmd_reg       <= CMD_ADD;
            qb_reg        <= '0;
            qg_reg        <= '0;
            qr_reg        <= '0;
            used_reg      <= '0;
            ovf_reg       <= 1'b0;
            rd_idx_reg    <= '0;
            pend_reg      <= 1'b0;
            pend_idx_reg  <= '0;
            best_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_b_reg     <= '0;
            out_g_reg     <= '0;
            out_r_reg     <= '0;
            out_cnt_reg   <= '0;
            out_used_reg  <= '0;
            out_empty_reg <= 1'b0;
            out_drop_reg  <= 1'b0;
        end
        else
        begin
            if ((state_reg == ST_RESULT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        rd_idx_reg <= '0;
                        pend_reg   <= 1'b0;
                        best_reg   <= '0;
                        qb_reg     <= quantize(blue_in);
                        qg_reg     <= quantize(green_in);
                        qr_reg     <= quantize(red_in);
                        unique case (cmd)
                            CMD_ADD:
                            begin
                                cmd_reg   <= CMD_ADD;
                                state_reg <= ST_SCAN;
                            end
                            CMD_REPORT:
                            begin
                                cmd_reg   <= CMD_REPORT;
                                state_reg <= ST_SCAN;
                            end
                            CMD_CLEAR:
                            begin
                                used_reg <= '0;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    pend_reg     <= issue;
                    pend_idx_reg <= rd_idx_reg[IDX_W-1:0];
                    if (issue)
                    begin
                        rd_idx_reg <= rd_idx_reg + 1'b1;
                    end
                    if ((cmd_reg == CMD_REPORT) && better)
                    begin
                        best_reg <= rd_data;
                    end
                    if (hit)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (scan_end)
                    begin
                        if (cmd_reg == CMD_ADD)
                        begin
                            if (room)
                            begin
                                used_reg <= used_reg + 1'b1;
                            end
                            else
                            begin
                                ovf_reg <= 1'b1;
                            end
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            state_reg <= ST_RESULT;
                        end
                    end
                end
                ST_RESULT:
                begin
                    if (out_free)
                    begin
                        out_empty_reg <= (used_reg == '0);
                        out_used_reg  <= used_reg;
                        out_drop_reg  <= ovf_reg;
                        out_b_reg     <= (used_reg == '0) ? '0 : best_reg.blue;
                        out_g_reg     <= (used_reg == '0) ? '0 : best_reg.green;
                        out_r_reg     <= (used_reg == '0) ? '0 : best_reg.red;
                        out_cnt_reg   <= (used_reg == '0) ? '0 : best_reg.count;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign mode_blue      = out_b_reg;
    assign mode_green     = out_g_reg;
    assign mode_red       = out_r_reg;
    assign mode_count     = out_cnt_reg;
    assign entries_used   = out_used_reg;
    assign table_empty    = out_empty_reg;
    assign colors_dropped = out_drop_reg;

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= USED_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_drop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |=> ovf_reg)
        else $error("dropped flag cleared");

    a_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> (state_reg == ST_SCAN) && (cmd_reg == CMD_ADD))
        else $error("table write outside an add scan");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg && $stable(out_cnt_reg)
            && $stable(out_b_reg) && $stable(out_used_reg))
        else $error("stalled result overwritten");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_empty_reg) |-> (out_cnt_reg == '0) && (out_used_reg == '0))
        else $error("empty report carries data");

endmodule

>>> design/qctm_table.sv
// Color table storage: one write port, one read port, registered read data.
// Depends on qctm_pkg.
module qctm_table (
    input  logic                    clk,
    input  qctm_pkg::tbl_wr_t       wr,
    input  logic                    rd_en,
    input  logic [qctm_pkg::IDX_W-1:0] rd_addr,
    output qctm_pkg::entry_t        rd_data
);
    import qctm_pkg::*;

    entry_t mem [TABLE_DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> tb/tb.sv
// Testbench for quantized_color_tally_mode: random and directed add, report and clear words.
// A scoreboard class predicts every report and checks the result words in order.
// Depends on qctm_pkg and the quantized_color_tally_mode RTL.
module tb;
    import qctm_pkg::*;

    localparam logic [1:0]             CMD_UNUSED  = 2'd3;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX   = '1;
    localparam int                     NUM_COLORS  = 1331;
    localparam int                     STALL_LIMIT = 2000;

    typedef struct packed {
        logic [7:0]             blue;
        logic [7:0]             green;
        logic [7:0]             red;
        logic [COUNT_WIDTH-1:0] count;
        logic [USED_W-1:0]      used;
        logic                   empty;
        logic                   dropped;
    } tally_report_t;

    class tally_scoreboard;
        entry_t        colors[TABLE_DEPTH];
        int unsigned   used;
        bit            dropped;
        tally_report_t expected_reports[$];
        int            errors;
        int            checked;

        function logic [7:0] bin_channel(logic [7:0] x);
            if (x < 8'd44)
                return 8'd10;
            if (x >= 8'd224)
                return 8'd245;
            return 8'(53 + 20 * ((int'(x) - 44) / 20));
        endfunction

        function void note_word(logic [1:0] c, logic [7:0] b, logic [7:0] g, logic [7:0] r);
            entry_t        probe;
            tally_report_t rep;
            int            hit;
            int            best;
            hit = -1;
            if (c == CMD_ADD)
            begin
                probe.blue  = bin_channel(b);
                probe.green = bin_channel(g);
                probe.red   = bin_channel(r);
                probe.count = '0;
                for (int k = 0; k < used; k++)
                begin
                    if (hit < 0 && colors[k].blue == probe.blue
                        && colors[k].green == probe.green && colors[k].red == probe.red)
                        hit = k;
                end
                if (hit >= 0)
                begin
                    if (colors[hit].count != COUNT_MAX)
                        colors[hit].count = colors[hit].count + 1'b1;
                end
                else if (used < TABLE_DEPTH)
                begin
                    colors[used] = probe;
                    used++;
                end
                else
                    dropped = 1'b1;
            end
            else if (c == CMD_CLEAR)
                used = 0;
            else if (c == CMD_REPORT)
            begin
                best = 0;
                for (int k = 1; k < used; k++)
                begin
                    if (colors[k].count > colors[best].count)
                        best = k;
                end
                rep = '0;
                if (used == 0)
                    rep.empty = 1'b1;
                else
                begin
                    rep.blue  = colors[best].blue;
                    rep.green = colors[best].green;
                    rep.red   = colors[best].red;
                    rep.count = colors[best].count;
                end
                rep.used    = USED_W'(used);
                rep.dropped = dropped;
                expected_reports = {expected_reports, rep};
            end
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch: %s", msg);
        endtask

        task field_check(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("report %0d %s got %0h want %0h", checked, name, got, want));
        endtask

        task check_report(tally_report_t got);
            tally_report_t want;
            if (expected_reports.size() == 0)
            begin
                report($sformatf("result word with no report pending: %h", got));
                return;
            end
            want = expected_reports.pop_front();
            checked++;
            field_check("mode_blue", 32'(got.blue), 32'(want.blue));
            field_check("mode_green", 32'(got.green), 32'(want.green));
            field_check("mode_red", 32'(got.red), 32'(want.red));
            field_check("mode_count", 32'(got.count), 32'(want.count));
            field_check("entries_used", 32'(got.used), 32'(want.used));
            field_check("table_empty", 32'(got.empty), 32'(want.empty));
            field_check("colors_dropped", 32'(got.dropped), 32'(want.dropped));
        endtask

        function int pending();
            return expected_reports.size();
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [1:0]             cmd;
    logic [7:0]             blue_in;
    logic [7:0]             green_in;
    logic [7:0]             red_in;
    logic                   out_valid;
    logic                   out_stall;
    logic [7:0]             mode_blue;
    logic [7:0]             mode_green;
    logic [7:0]             mode_red;
    logic [COUNT_WIDTH-1:0] mode_count;
    logic [USED_W-1:0]      entries_used;
    logic                   table_empty;
    logic                   colors_dropped;

    tally_scoreboard sb;
    bit              in_idle_on;
    bit              out_idle_on;
    int              words_sent;
    int              quiet_cycles;

    quantized_color_tally_mode i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cmd            (cmd),
        .blue_in        (blue_in),
        .green_in       (green_in),
        .red_in         (red_in),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .mode_blue      (mode_blue),
        .mode_green     (mode_green),
        .mode_red       (mode_red),
        .mode_count     (mode_count),
        .entries_used   (entries_used),
        .table_empty    (table_empty),
        .colors_dropped (colors_dropped)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no word moved for %0d cycles", quiet_cycles);
            $display("simulation failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic [7:0] raw_in_bin(int lvl);
        if (lvl == 0)
            return 8'($urandom_range(0, 43));
        if (lvl == 10)
            return 8'($urandom_range(224, 255));
        return 8'(44 + 20 * (lvl - 1) + $urandom_range(0, 19));
    endfunction

    function automatic logic [7:0] rnd_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_word(logic [1:0] c, logic [7:0] b, logic [7:0] g, logic [7:0] r);
        int gap;
        gap = in_idle_on ? $urandom_range(0, 6) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        cmd      <= c;
        blue_in  <= b;
        green_in <= g;
        red_in   <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_word(c, b, g, r);
        words_sent++;
    endtask

    // color code: blue level * 121 + green level * 11 + red level
    task automatic send_color(int code);
        send_word(CMD_ADD, raw_in_bin(code / 121), raw_in_bin((code / 11) % 11),
                  raw_in_bin(code % 11));
    endtask

    task automatic hold_for_reports();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(int n_words, int psize);
        int palette[$];
        int roll;
        for (int k = 0; k < psize; k++)
            palette = {palette, int'($urandom_range(0, NUM_COLORS - 1))};
        in_idle_on  = 1'($urandom_range(0, 1));
        out_idle_on = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 3) != 0)
            send_word(CMD_CLEAR, rnd_byte(), rnd_byte(), rnd_byte());
        for (int k = 0; k < n_words; k++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 68)
                send_color(palette[$urandom_range(0, psize - 1)]);
            else if (roll < 88)
                send_word(CMD_REPORT, rnd_byte(), rnd_byte(), rnd_byte());
            else if (roll < 93)
                send_word(CMD_ADD, rnd_byte(), rnd_byte(), rnd_byte());
            else if (roll < 96)
                send_word(CMD_CLEAR, rnd_byte(), rnd_byte(), rnd_byte());
            else
                send_word(CMD_UNUSED, rnd_byte(), rnd_byte(), rnd_byte());
        end
    endtask

    // result side
    initial
    begin
        tally_report_t got;
        int            gap;
        out_stall = 1'b0;
        forever
        begin
            gap = out_idle_on ? $urandom_range(0, 6) : 0;
            while (gap > 0)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
                gap--;
            end
            @(negedge clk);
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            got.blue    = mode_blue;
            got.green   = mode_green;
            got.red     = mode_red;
            got.count   = mode_count;
            got.used    = entries_used;
            got.empty   = table_empty;
            got.dropped = colors_dropped;
            sb.check_report(got);
        end
    end

    initial
    begin
        int rep_code;
        int base;
        sb           = new();
        in_valid     = 1'b0;
        cmd          = CMD_ADD;
        blue_in      = '0;
        green_in     = '0;
        red_in       = '0;
        rst_n        = 1'b0;
        words_sent   = 0;
        in_idle_on   = 1'b1;
        out_idle_on  = 1'b1;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // quantizer edges, tie order, empty table, unused command
        send_word(CMD_REPORT, 8'd0, 8'd0, 8'd0);
        send_word(CMD_ADD, 8'd0, 8'd0, 8'd0);
        send_word(CMD_ADD, 8'd43, 8'd44, 8'd63);
        send_word(CMD_ADD, 8'd64, 8'd223, 8'd224);
        send_word(CMD_ADD, 8'd255, 8'd255, 8'd255);
        send_word(CMD_ADD, 8'd0, 8'd43, 8'd17);
        send_word(CMD_REPORT, 8'd255, 8'd255, 8'd255);
        send_word(CMD_UNUSED, rnd_byte(), rnd_byte(), rnd_byte());
        send_word(CMD_ADD, 8'd255, 8'd224, 8'd250);
        send_word(CMD_REPORT, rnd_byte(), rnd_byte(), rnd_byte());
        send_word(CMD_ADD, 8'd230, 8'd240, 8'd255);
        send_word(CMD_REPORT, rnd_byte(), rnd_byte(), rnd_byte());
        send_word(CMD_ADD, 8'd83, 8'd84, 8'd203);
        send_word(CMD_CLEAR, 8'd255, 8'd255, 8'd255);
        send_word(CMD_REPORT, rnd_byte(), rnd_byte(), rnd_byte());
        send_word(CMD_ADD, 8'd100, 8'd150, 8'd200);
        send_word(CMD_REPORT, rnd_byte(), rnd_byte(), rnd_byte());
        send_word(CMD_UNUSED, 8'd255, 8'd255, 8'd255);
        send_word(CMD_ADD, 8'd101, 8'd160, 8'd210);
        send_word(CMD_REPORT, 8'd0, 8'd0, 8'd0);
        hold_for_reports();

        // repeated color with a single entry, no idling
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        rep_code    = $urandom_range(0, NUM_COLORS - 1);
        send_word(CMD_CLEAR, rnd_byte(), rnd_byte(), rnd_byte());
        repeat (20)
            send_color(rep_code);
        send_word(CMD_REPORT, rnd_byte(), rnd_byte(), rnd_byte());
        send_color((rep_code + 1) % NUM_COLORS);
        send_color(rep_code);
        send_word(CMD_REPORT, rnd_byte(), rnd_byte(), rnd_byte());
        hold_for_reports();

        for (int p = 0; p < 5; p++)
            run_phase(100, $urandom_range(1, 30));

        // fill the table and overflow it
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
        base        = $urandom_range(0, NUM_COLORS - 1);
        send_word(CMD_CLEAR, rnd_byte(), rnd_byte(), rnd_byte());
        for (int k = 0; k < TABLE_DEPTH + 2; k++)
            send_color((base + 7 * k) % NUM_COLORS);
        send_word(CMD_REPORT, rnd_byte(), rnd_byte(), rnd_byte());
        send_color((base + 7 * (TABLE_DEPTH - 1)) % NUM_COLORS);
        send_color(base);
        send_color((base + 7 * (TABLE_DEPTH - 1)) % NUM_COLORS);
        send_word(CMD_REPORT, rnd_byte(), rnd_byte(), rnd_byte());
        send_word(CMD_CLEAR, rnd_byte(), rnd_byte(), rnd_byte());
        send_word(CMD_REPORT, rnd_byte(), rnd_byte(), rnd_byte());
        hold_for_reports();

        for (int p = 0; p < 7; p++)
        begin
            run_phase(120, $urandom_range(20, 90));
            if ($urandom_range(0, 1) != 0)
                hold_for_reports();
        end

        hold_for_reports();
        repeat (150) @(posedge clk);

        $display("run: %0d words sent, %0d reports checked, %0d mismatches",
                 words_sent, sb.checked, sb.errors);
        $display("covered: bin edges, ties, repeat counts, table overflow, clear, unused cmd");
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

>>> quantized_color_tally_mode.f
design/qctm_pkg.sv
design/qctm_table.sv
design/quantized_color_tally_mode.sv
tb/tb.sv
